FILE: src/xoshiro128_generator_top_macros.svh
// assertion macros shared by the xoshiro128 generator rtl
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef XOSHIRO128_GENERATOR_TOP_MACROS_SVH
`define XOSHIRO128_GENERATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define XO_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("xoshiro check failed (same cycle)");

// next-cycle implication
`define XO_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("xoshiro check failed (next cycle)");

`else

`define XO_ASSERT_IMPL(label, ck, rn, ante, cons)
`define XO_ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

FILE: src/xoshiro_pkg.sv
// shared types and codes for the xoshiro128 generator
// no dependencies
package xoshiro_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [1:0]        action_t;

    // request codes
    localparam action_t ACT_STARSTAR = 2'd0;
    localparam action_t ACT_PLUS     = 2'd1;
    localparam action_t ACT_RANGED   = 2'd2;
    localparam action_t ACT_SEED     = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic seed_wr;
        logic draw_ss;
        logic draw_plus;
        logic load_range;
        logic div_start;
        logic div_sel_quot;
        logic load_scale;
        logic load_limit;
        logic add_low;
        logic emit;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic range_zero;
        logic reject;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

FILE: src/xoshiro_div.sv
// restoring divider, one quotient bit per cycle
// depends on xoshiro_pkg and the assertion macro header
`include "xoshiro128_generator_top_macros.svh"

module xoshiro_div
    import xoshiro_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t dividend,
    input  word_t divisor,
    output logic  done,
    output word_t quotient
);

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    word_t             rem_reg,  rem_next;
    word_t             quo_reg,  quo_next;
    word_t             dsr_reg,  dsr_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        shifted   = {rem_reg, quo_reg[WORD_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[WORD_W])
            begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `XO_ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy_reg)
    `XO_ASSERT_IMPL(a_done_idle, clk, rst_n, done_reg, !busy_reg)

endmodule

FILE: src/xoshiro_dp.sv
// datapath: generator state, draw logic, range registers, divider, output register
// depends on xoshiro_pkg, xoshiro_div and the assertion macro header
`include "xoshiro128_generator_top_macros.svh"

module xoshiro_dp
    import xoshiro_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  logic [1:0] seed_index,
    input  word_t      seed_word,
    input  word_t      range_low,
    input  word_t      range_high,
    input  logic       out_ready,
    output logic       out_valid,
    output word_t      value
);

    word_t s_reg [4];
    word_t s_next [4];
    word_t r_reg, r_next;
    word_t range_reg, low_reg, scale_reg, limit_reg;
    word_t out_value_reg;
    logic  out_valid_reg, out_valid_next;
    word_t mul5, rot7, starstar, plus_out, tshift;
    word_t div_a, div_b, div_q;
    logic  div_done;

    // star-star and plus outputs from the current state
    always_comb
    begin
        mul5     = (s_reg[1] << 2) + s_reg[1];
        rot7     = {mul5[WORD_W-8:0], mul5[WORD_W-1:WORD_W-7]};
        starstar = (rot7 << 3) + rot7;
        plus_out = s_reg[0] + s_reg[3];
    end

    // state update
    always_comb
    begin
        word_t n0, n1, n2, n3;
        tshift = s_reg[1] << 9;
        n2 = s_reg[2] ^ s_reg[0];
        n3 = s_reg[3] ^ s_reg[1];
        n1 = s_reg[1] ^ n2;
        n0 = s_reg[0] ^ n3;
        n2 = n2 ^ tshift;
        n3 = {n3[WORD_W-12:0], n3[WORD_W-1:WORD_W-11]};
        s_next = s_reg;
        if (cmd.draw_ss || cmd.draw_plus)
        begin
            s_next[0] = n0;
            s_next[1] = n1;
            s_next[2] = n2;
            s_next[3] = n3;
        end
        else if (cmd.seed_wr)
        begin
            s_next[seed_index] = seed_word;
        end
    end

    always_comb
    begin
        r_next = r_reg;
        if (cmd.draw_ss)
        begin
            r_next = starstar;
        end
        else if (cmd.draw_plus)
        begin
            r_next = plus_out;
        end
        else if (cmd.add_low)
        begin
            r_next = div_q + low_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s_reg         <= s_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        if (cmd.load_range)
        begin
            range_reg <= (range_high - range_low) + 1'b1;
            low_reg   <= range_low;
        end
        if (cmd.load_scale)
        begin
            scale_reg <= div_q;
        end
        if (cmd.load_limit)
        begin
            limit_reg <= range_reg * scale_reg;
        end
        if (cmd.emit)
        begin
            out_value_reg <= r_reg;
        end
    end

    // scale = all ones / range, then the draw / scale
    assign div_a = cmd.div_sel_quot ? r_reg : '1;
    assign div_b = cmd.div_sel_quot ? scale_reg : range_reg;

    xoshiro_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sts.range_zero = (range_reg == '0);
    assign sts.reject     = (r_reg >= limit_reg);
    assign sts.div_done   = div_done;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;

    // an unseeded generator stays unseeded across a draw
    `XO_ASSERT_NEXT(a_zero_state, clk, rst_n,
        (s_reg[0] == '0) && (s_reg[1] == '0) && (s_reg[2] == '0) && (s_reg[3] == '0)
        && (cmd.draw_ss || cmd.draw_plus) && !cmd.seed_wr,
        (s_reg[0] == '0) && (s_reg[1] == '0) && (s_reg[2] == '0) && (s_reg[3] == '0))

endmodule

FILE: src/xoshiro_ctrl.sv
// controller state machine for the xoshiro128 generator
// depends on xoshiro_pkg and the assertion macro header
`include "xoshiro128_generator_top_macros.svh"

module xoshiro_ctrl
    import xoshiro_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  action_t action,
    input  sts_t    sts,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_RANGE_CHK  = 3'd1;
    localparam logic [2:0] ST_WAIT_SCALE = 3'd2;
    localparam logic [2:0] ST_LIMIT      = 3'd3;
    localparam logic [2:0] ST_DRAW       = 3'd4;
    localparam logic [2:0] ST_CHECK      = 3'd5;
    localparam logic [2:0] ST_WAIT_Q     = 3'd6;
    localparam logic [2:0] ST_EMIT       = 3'd7;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (action)
                        ACT_STARSTAR:
                        begin
                            cmd.draw_ss = 1'b1;
                            state_next  = ST_EMIT;
                        end
                        ACT_PLUS:
                        begin
                            cmd.draw_plus = 1'b1;
                            state_next    = ST_EMIT;
                        end
                        ACT_RANGED:
                        begin
                            cmd.load_range = 1'b1;
                            state_next     = ST_RANGE_CHK;
                        end
                        default:
                        begin
                            cmd.seed_wr = 1'b1;
                        end
                    endcase
                end
            end
            ST_RANGE_CHK:
            begin
                if (sts.range_zero)
                begin
                    state_next = ST_DRAW;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_WAIT_SCALE;
                end
            end
            ST_WAIT_SCALE:
            begin
                if (sts.div_done)
                begin
                    cmd.load_scale = 1'b1;
                    state_next     = ST_LIMIT;
                end
            end
            ST_LIMIT:
            begin
                cmd.load_limit = 1'b1;
                state_next     = ST_DRAW;
            end
            ST_DRAW:
            begin
                cmd.draw_ss = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.range_zero)
                begin
                    state_next = ST_EMIT;
                end
                else if (sts.reject)
                begin
                    state_next = ST_DRAW;
                end
                else
                begin
                    cmd.div_start    = 1'b1;
                    cmd.div_sel_quot = 1'b1;
                    state_next       = ST_WAIT_Q;
                end
            end
            ST_WAIT_Q:
            begin
                if (sts.div_done)
                begin
                    cmd.add_low = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `XO_ASSERT_IMPL(a_emit_free, clk, rst_n, cmd.emit, sts.out_free)
    `XO_ASSERT_NEXT(a_reject_redraw, clk, rst_n,
        (state_reg == ST_CHECK) && !sts.range_zero && sts.reject, state_reg == ST_DRAW)

endmodule

FILE: src/xoshiro128_generator_top.sv
// star-star or plus draw: draw register, then output register once that is free
// ranged draw: two divider passes plus a redraw per reject; a range that wraps to zero skips
// both divider passes; requests are taken one at a time
// the output register lets the next request enter while a result waits to be taken
// reset (rst_n, async, active low): state words cleared to zero, controller idle, no result
// depends on xoshiro_pkg, xoshiro_ctrl, xoshiro_dp
module xoshiro128_generator_top
    import xoshiro_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // request channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [1:0] seed_index,
    input  word_t      seed_word,
    input  word_t      range_low,
    input  word_t      range_high,
    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output word_t      value
);

    // command and status bundles between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: decodes the request, steps through range setup,
    // draw and reject loop, final division and the hand-off to the output register
    xoshiro_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: four state words, draw logic, shared serial divider,
    // limit multiplier and the output register that holds a result until its transfer
    xoshiro_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .seed_index (seed_index),
        .seed_word  (seed_word),
        .range_low  (range_low),
        .range_high (range_high),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .value      (value)
    );

endmodule
